// ===== hdl/fat12cuc_pkg.sv =====
package fat12cuc_pkg;

    localparam int CNT_W = 13;

    localparam logic [CNT_W-1:0] CNT_MAX      = 13'h1FFF;
    localparam logic [CNT_W-1:0] MAX_CLUSTERS = 13'd4096;
    localparam logic [CNT_W-1:0] RESV_INIT    = 13'd2;
    localparam logic [CNT_W-1:0] FIRST_ENTRY  = 13'd2;

    // byte position inside a three-byte group
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    localparam logic [11:0] ENT_FREE     = 12'h000;
    localparam logic [11:0] ENT_USED_LO  = 12'h002;
    localparam logic [11:0] ENT_USED_HI  = 12'hFEF;
    localparam logic [11:0] ENT_RESV_LO  = 12'hFF0;
    localparam logic [11:0] ENT_RESV_HI  = 12'hFF6;
    localparam logic [11:0] ENT_BAD      = 12'hFF7;
    localparam logic [11:0] ENT_TERM_LO  = 12'hFF8;

    localparam int OUT_W = 72;

    typedef struct packed {
        logic take;     // an entry completes on this byte
        logic free;
        logic used;
        logic resv;
        logic broken;
        logic term;
    } t_entry_hit;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v,
                                                 input logic en);
        logic [CNT_W-1:0] r;
        r = v;
        if (en && (v != CNT_MAX)) begin
            r = v + 13'd1;
        end
        return r;
    endfunction

endpackage

// ===== hdl/fat12_cluster_usage_counter.sv =====
// A last byte is registered, then its report is loaded into the result register.
// Throughput: one table byte per cycle; input register and result register
// let a byte be taken while a report waits, unless a further last byte arrives.
// Reset (i_rst_n low, synchronous): stream state cleared, reserved total set
// to 2, cluster bound set to 4096, no report pending.
module fat12_cluster_usage_counter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fat12cuc_pkg::CNT_W-1:0]      i_cfg_data,      // cluster_bound
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [7:0]                          i_s_axis_tdata,  // fat_byte
    input  logic                                i_s_axis_tlast,  // last_byte
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // used_count, free_count, end_count, broken_count, reserved_count, zero pad
    output logic [fat12cuc_pkg::OUT_W-1:0]      o_m_axis_tdata
);
    import fat12cuc_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic             w_consume;

    logic [CNT_W-1:0] r_bound;
    logic [1:0]       r_phase;
    logic [7:0]       r_held_bits;
    logic [CNT_W-1:0] r_entry_index;
    logic [CNT_W-1:0] r_used_total;
    logic [CNT_W-1:0] r_free_total;
    logic [CNT_W-1:0] r_end_total;
    logic [CNT_W-1:0] r_broken_total;
    logic [CNT_W-1:0] r_reserved_total;

    logic [1:0]       n_phase;
    logic [7:0]       n_held_bits;
    logic [CNT_W-1:0] n_entry_index;
    logic [CNT_W-1:0] n_used_total;
    logic [CNT_W-1:0] n_free_total;
    logic [CNT_W-1:0] n_end_total;
    logic [CNT_W-1:0] n_broken_total;
    logic [CNT_W-1:0] n_reserved_total;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    t_entry_hit       w_hit;

    assign o_cfg_ready     = 1'b1;
    assign w_consume       = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_consume;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    fat12cuc_entry u_entry (
        .i_phase (r_phase),
        .i_held  (r_held_bits),
        .i_byte  (r_in_byte),
        .i_index (r_entry_index),
        .i_bound (r_bound),
        .o_hit   (w_hit)
    );

    always_comb begin
        case (r_phase)
            PH_SECOND: begin
                n_phase     = PH_THIRD;
                n_held_bits = r_in_byte;
            end
            PH_THIRD: begin
                n_phase     = PH_FIRST;
                n_held_bits = 8'h00;
            end
            default: begin
                n_phase     = PH_SECOND;
                n_held_bits = r_in_byte;
            end
        endcase
        n_entry_index    = sat_inc(r_entry_index, w_hit.take);
        n_used_total     = sat_inc(r_used_total, w_hit.used);
        n_free_total     = sat_inc(r_free_total, w_hit.free);
        n_end_total      = sat_inc(r_end_total, w_hit.term);
        n_broken_total   = sat_inc(r_broken_total, w_hit.broken);
        n_reserved_total = sat_inc(r_reserved_total, w_hit.resv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_in_last        <= 1'b0;
            r_in_byte        <= 8'h00;
            r_bound          <= MAX_CLUSTERS;
            r_phase          <= PH_FIRST;
            r_held_bits      <= 8'h00;
            r_entry_index    <= '0;
            r_used_total     <= '0;
            r_free_total     <= '0;
            r_end_total      <= '0;
            r_broken_total   <= '0;
            r_reserved_total <= RESV_INIT;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_bound <= (i_cfg_data > MAX_CLUSTERS) ? MAX_CLUSTERS : i_cfg_data;
            end

            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
                r_in_byte  <= i_s_axis_tdata;
                r_in_last  <= i_s_axis_tlast;
            end

            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (w_consume) begin
                if (r_in_last) begin
                    r_out_valid      <= 1'b1;
                    r_phase          <= PH_FIRST;
                    r_held_bits      <= 8'h00;
                    r_entry_index    <= '0;
                    r_used_total     <= '0;
                    r_free_total     <= '0;
                    r_end_total      <= '0;
                    r_broken_total   <= '0;
                    r_reserved_total <= RESV_INIT;
                end else begin
                    r_phase          <= n_phase;
                    r_held_bits      <= n_held_bits;
                    r_entry_index    <= n_entry_index;
                    r_used_total     <= n_used_total;
                    r_free_total     <= n_free_total;
                    r_end_total      <= n_end_total;
                    r_broken_total   <= n_broken_total;
                    r_reserved_total <= n_reserved_total;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume && r_in_last) begin
            r_out_data <= {7'd0, n_reserved_total, n_broken_total, n_end_total,
                           n_free_total, n_used_total};
        end
    end

    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && r_in_last) |=> (r_phase == PH_FIRST) && (r_entry_index == '0)
                                     && o_m_axis_tvalid)
        else $error("stream state not cleared after report");

    a_end_in_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end_total <= r_used_total)
        else $error("end total exceeds used total");

    a_resv_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reserved_total >= RESV_INIT)
        else $error("reserved total below its base");

    a_held_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FIRST) |-> (r_held_bits == 8'h00))
        else $error("held bits left over at group start");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !(w_consume && r_in_last))
        else $error("pending report overwritten");

endmodule

// ===== hdl/fat12cuc_entry.sv =====
module fat12cuc_entry (
    input  logic [1:0]                        i_phase,
    input  logic [7:0]                        i_held,
    input  logic [7:0]                        i_byte,
    input  logic [fat12cuc_pkg::CNT_W-1:0]    i_index,
    input  logic [fat12cuc_pkg::CNT_W-1:0]    i_bound,
    output fat12cuc_pkg::t_entry_hit          o_hit
);
    import fat12cuc_pkg::*;

    logic [11:0] w_entry;
    logic        w_take;
    logic        w_count;

    always_comb begin
        case (i_phase)
            PH_SECOND: begin
                w_entry = {i_byte[3:0], i_held};
                w_take  = 1'b1;
            end
            PH_THIRD: begin
                w_entry = {i_byte, i_held[7:4]};
                w_take  = 1'b1;
            end
            default: begin
                w_entry = {4'h0, i_byte};
                w_take  = 1'b0;
            end
        endcase
    end

    assign w_count = w_take && (i_index >= FIRST_ENTRY) && (i_index < i_bound);

    always_comb begin
        o_hit        = '0;
        o_hit.take   = w_take;
        if (w_count) begin
            o_hit.free   = (w_entry == ENT_FREE);
            o_hit.broken = (w_entry == ENT_BAD);
            o_hit.resv   = (w_entry >= ENT_RESV_LO) && (w_entry <= ENT_RESV_HI);
            o_hit.term   = (w_entry >= ENT_TERM_LO);
            o_hit.used   = ((w_entry >= ENT_USED_LO) && (w_entry <= ENT_USED_HI))
                           || o_hit.resv || o_hit.term;
        end
    end

endmodule
